FILE: design/ppp_pkg.sv
// Package with widths, types and helpers for the pinhole point projector.
package ppp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int PIXEL_BITS = 16;
  localparam int COEF_W     = 32;
  localparam int PROD_W     = 64;
  localparam int SUM_W      = 66;
  localparam int MAG_W      = 65;
  localparam int QBITS      = PIXEL_BITS + 1;
  localparam int NCOEF      = 12;

  localparam logic       OP_LOAD    = 1'b0;
  localparam logic       OP_PROJECT = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  // One divider cell's payload: running remainders and quotients of both coordinates.
  typedef struct packed {
    logic               valid;
    logic [MAG_W-1:0]   num_u;
    logic [MAG_W-1:0]   num_v;
    logic [MAG_W-1:0]   rem_u;
    logic [MAG_W-1:0]   rem_v;
    logic [MAG_W-1:0]   den;
    logic [QBITS-1:0]   q_u;
    logic [QBITS-1:0]   q_v;
    logic               big_u;
    logic               big_v;
    logic               neg_u;
    logic               neg_v;
    logic               zero;
  } div_cell_t;

endpackage

FILE: design/ppp_div_cell.sv
// One restoring-division cell: brings in one numerator bit per coordinate and subtracts.
module ppp_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [6:0]        bit_pos,
  input  ppp_pkg::div_cell_t prev,
  output ppp_pkg::div_cell_t cur
);

  ppp_pkg::div_cell_t nxt;
  logic [ppp_pkg::MAG_W:0] ru, rv;

  always_comb begin
    nxt = prev;
    ru  = {prev.rem_u, prev.num_u[bit_pos]};
    rv  = {prev.rem_v, prev.num_v[bit_pos]};
    // Remainder stays below the divisor, so dropping the top bit after subtraction is safe.
    if (ru >= {1'b0, prev.den}) begin
      ru = ru - {1'b0, prev.den};
      if (bit_pos >= 7'(ppp_pkg::QBITS)) nxt.big_u = 1'b1;
      else nxt.q_u[bit_pos[4:0]] = 1'b1;
    end
    if (rv >= {1'b0, prev.den}) begin
      rv = rv - {1'b0, prev.den};
      if (bit_pos >= 7'(ppp_pkg::QBITS)) nxt.big_v = 1'b1;
      else nxt.q_v[bit_pos[4:0]] = 1'b1;
    end
    nxt.rem_u = ru[ppp_pkg::MAG_W-1:0];
    nxt.rem_v = rv[ppp_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (en) begin
      cur.valid <= prev.valid;
    end
    if (en) begin
      cur.num_u <= nxt.num_u; cur.num_v <= nxt.num_v;
      cur.rem_u <= nxt.rem_u; cur.rem_v <= nxt.rem_v;
      cur.den   <= nxt.den;   cur.q_u   <= nxt.q_u;  cur.q_v <= nxt.q_v;
      cur.big_u <= nxt.big_u; cur.big_v <= nxt.big_v;
      cur.neg_u <= nxt.neg_u; cur.neg_v <= nxt.neg_v; cur.zero <= nxt.zero;
    end
  end

endmodule

FILE: design/pinhole_point_projector_unit.sv
// Top level of the pinhole point projector: matrix store, dot products, divider chain.
//
// The block accepts one beat per cycle while the output register is empty or being
// taken. A load beat with an index below 12 writes one matrix coefficient and produces
// nothing. A project beat produces one result beat. It passes through three registered
// stages of multiplication, summation and sign handling, then a row of 65 identical
// divider cells, one quotient bit per cell, and then a result register. That makes 69
// registers in all, and the first one is loaded at the accepting edge. The whole
// pipeline advances together whenever the output register is empty or being taken, so
// throughput is one point per cycle when the downstream side keeps up. Loads take effect
// for every project beat that follows them. The matrix resets to zero.
module pinhole_point_projector_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata from bit 0: coef_index[3:0], coef_value[31:0], point_x, point_y, point_z,
  // point_w (32 bits each), 4 zero bits; 168 bits.
  input  logic [167:0] s_tdata,
  // tuser: opcode.
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata from bit 0: pixel_u[15:0], pixel_v[15:0], status[1:0], 6 zero bits.
  output logic [39:0]  m_tdata
);

  localparam int NC = ppp_pkg::MAG_W;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic acc;
  assign acc = s_tvalid && s_tready;

  logic signed [31:0] mat [ppp_pkg::NCOEF];
  logic [3:0] idx;
  assign idx = s_tdata[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ppp_pkg::NCOEF; i++) mat[i] <= '0;
    end else if (acc && s_tuser == ppp_pkg::OP_LOAD && idx < 4'(ppp_pkg::NCOEF)) begin
      mat[idx] <= s_tdata[35:4];
    end
  end

  logic signed [31:0] pt [4];
  always_comb begin
    for (int c = 0; c < 4; c++) pt[c] = s_tdata[36+32*c +: 32];
  end

  // Stage 1: twelve products, one multiplier each.
  logic                            v1;
  logic signed [ppp_pkg::PROD_W-1:0] prod [ppp_pkg::NCOEF];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= acc && s_tuser == ppp_pkg::OP_PROJECT;
    if (en) begin
      for (int i = 0; i < ppp_pkg::NCOEF; i++) prod[i] <= mat[i] * pt[i%4];
    end
  end

  // Stage 2: row sums.
  logic v2;
  logic signed [ppp_pkg::SUM_W-1:0] sa, sb, sd;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      sa <= ppp_pkg::SUM_W'(prod[0]) + ppp_pkg::SUM_W'(prod[1])
          + ppp_pkg::SUM_W'(prod[2]) + ppp_pkg::SUM_W'(prod[3]);
      sb <= ppp_pkg::SUM_W'(prod[4]) + ppp_pkg::SUM_W'(prod[5])
          + ppp_pkg::SUM_W'(prod[6]) + ppp_pkg::SUM_W'(prod[7]);
      sd <= ppp_pkg::SUM_W'(prod[8]) + ppp_pkg::SUM_W'(prod[9])
          + ppp_pkg::SUM_W'(prod[10]) + ppp_pkg::SUM_W'(prod[11]);
    end
  end

  // Stage 3: magnitudes and signs feed the first divider cell.
  ppp_pkg::div_cell_t chain [NC+1];
  ppp_pkg::div_cell_t head;
  logic [ppp_pkg::SUM_W-1:0] ma, mb, md;
  always_comb begin
    ma = sa[ppp_pkg::SUM_W-1] ? ppp_pkg::SUM_W'(-sa) : sa;
    mb = sb[ppp_pkg::SUM_W-1] ? ppp_pkg::SUM_W'(-sb) : sb;
    md = sd[ppp_pkg::SUM_W-1] ? ppp_pkg::SUM_W'(-sd) : sd;
  end
  always_ff @(posedge clk) begin
    if (rst) head.valid <= 1'b0;
    else if (en) head.valid <= v2;
    if (en) begin
      head.num_u <= ma[NC-1:0];
      head.num_v <= mb[NC-1:0];
      head.den   <= md[NC-1:0];
      head.rem_u <= '0; head.rem_v <= '0;
      head.q_u   <= '0; head.q_v   <= '0;
      head.big_u <= 1'b0; head.big_v <= 1'b0;
      head.neg_u <= sa[ppp_pkg::SUM_W-1] ^ sd[ppp_pkg::SUM_W-1];
      head.neg_v <= sb[ppp_pkg::SUM_W-1] ^ sd[ppp_pkg::SUM_W-1];
      head.zero  <= (sd == '0);
    end
  end
  assign chain[0] = head;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    ppp_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .bit_pos(7'(NC-1-k)),
      .prev(chain[k]), .cur(chain[k+1])
    );
  end

  // Sign, saturation and zero-depth handling on the last cell's output.
  ppp_pkg::div_cell_t f;
  assign f = chain[NC];
  localparam logic [ppp_pkg::QBITS-1:0] MAXPOS =
    ppp_pkg::QBITS'((1 << (ppp_pkg::PIXEL_BITS-1)) - 1);
  localparam logic [ppp_pkg::QBITS-1:0] MAXNEG =
    ppp_pkg::QBITS'(1 << (ppp_pkg::PIXEL_BITS-1));
  logic su, sv;
  logic [ppp_pkg::PIXEL_BITS-1:0] pu, pv;
  always_comb begin
    su = f.big_u || (f.neg_u ? f.q_u > MAXNEG : f.q_u > MAXPOS);
    sv = f.big_v || (f.neg_v ? f.q_v > MAXNEG : f.q_v > MAXPOS);
    pu = su ? (f.neg_u ? MAXNEG[ppp_pkg::PIXEL_BITS-1:0] : MAXPOS[ppp_pkg::PIXEL_BITS-1:0])
            : (f.neg_u ? ppp_pkg::PIXEL_BITS'(-f.q_u) : f.q_u[ppp_pkg::PIXEL_BITS-1:0]);
    pv = sv ? (f.neg_v ? MAXNEG[ppp_pkg::PIXEL_BITS-1:0] : MAXPOS[ppp_pkg::PIXEL_BITS-1:0])
            : (f.neg_v ? ppp_pkg::PIXEL_BITS'(-f.q_v) : f.q_v[ppp_pkg::PIXEL_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= f.valid;
    if (en) begin
      if (f.zero) m_tdata <= {6'b0, ppp_pkg::ST_ZERO, 32'b0};
      else m_tdata <= {6'b0, (su || sv) ? ppp_pkg::ST_SAT : ppp_pkg::ST_OK,
                       16'(pv), 16'(pu)};
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] == ppp_pkg::ST_ZERO |-> m_tdata[31:0] == '0)
    else $error("zero depth with nonzero pixel");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:32] <= ppp_pkg::ST_SAT) else $error("bad status");

endmodule

FILE: verif/pinhole_point_projector_unit_tb.sv
// Self-checking testbench for the pinhole point projector unit.
module pinhole_point_projector_unit_tb;

  typedef struct {
    logic [15:0] pixel_u;
    logic [15:0] pixel_v;
    logic [1:0]  status;
  } pixel_t;

  // Scoreboard: holds its own copy of the matrix and the queue of expected pixels.
  class projection_board;
    logic signed [31:0] coef[ppp_pkg::NCOEF];
    pixel_t pending[$];
    int errors;
    int loads;
    int points;
    int zeros;
    int sats;

    function void clear();
      foreach (coef[i]) coef[i] = '0;
      pending.delete();
      errors = 0;
    endfunction

    // Exact signed quotient, truncated toward zero, clamped to the pixel range.
    function automatic logic [15:0] divide_clamp(logic signed [65:0] num,
                                                 logic signed [65:0] den,
                                                 ref bit sat);
      logic signed [67:0] q;
      logic signed [67:0] lim;
      lim = 68'sd1 <<< (ppp_pkg::PIXEL_BITS - 1);
      q = 68'(num) / 68'(den);
      if (q > lim - 1) begin
        sat = 1;
        return 16'(lim - 1);
      end
      if (q < -lim) begin
        sat = 1;
        return 16'(-lim);
      end
      return 16'(q);
    endfunction

    function void note_beat(logic op, logic [167:0] d);
      logic [3:0] idx;
      logic signed [31:0] pt[4];
      logic signed [65:0] acc[3];
      pixel_t px;
      bit sat;
      idx = d[3:0];
      if (op == ppp_pkg::OP_LOAD) begin
        loads++;
        if (idx < ppp_pkg::NCOEF) coef[idx] = d[35:4];
        return;
      end
      points++;
      for (int c = 0; c < 4; c++) pt[c] = d[36 + 32 * c +: 32];
      for (int r = 0; r < 3; r++) begin
        acc[r] = '0;
        for (int c = 0; c < 4; c++) acc[r] += 66'(64'(coef[r * 4 + c]) * 64'(pt[c]));
      end
      sat = 0;
      if (acc[2] == 0) begin
        px = '{16'd0, 16'd0, ppp_pkg::ST_ZERO};
        zeros++;
      end else begin
        px.pixel_u = divide_clamp(acc[0], acc[2], sat);
        px.pixel_v = divide_clamp(acc[1], acc[2], sat);
        px.status = sat ? ppp_pkg::ST_SAT : ppp_pkg::ST_OK;
        if (sat) sats++;
      end
      pending.insert(pending.size(), px);
    endfunction

    function void check_pixel(logic [39:0] d);
      pixel_t e;
      if (pending.size() == 0) begin
        $error("result beat with no point waiting: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.pixel_u) begin
        $error("pixel_u expected %0d actual %0d", $signed(e.pixel_u), $signed(d[15:0]));
        errors++;
      end
      if (d[31:16] !== e.pixel_v) begin
        $error("pixel_v expected %0d actual %0d", $signed(e.pixel_v), $signed(d[31:16]));
        errors++;
      end
      if (d[33:32] !== e.status) begin
        $error("status expected %0d actual %0d", e.status, d[33:32]);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [167:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [39:0] m_tdata;

  projection_board board;
  int send_idle_pct;
  int recv_idle_pct;

  pinhole_point_projector_unit DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: stalls at random, checks each accepted result beat.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) board.check_pixel(m_tdata);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sends one beat, idling beforehand at the current rate, and waits for acceptance.
  task automatic send_beat(logic op, logic [167:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_beat(op, d);
  endtask

  task automatic load_coef(logic [3:0] idx, logic [31:0] val);
    send_beat(ppp_pkg::OP_LOAD, {132'd0, val, idx});
  endtask

  task automatic project_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] w);
    send_beat(ppp_pkg::OP_PROJECT, {4'd0, w, z, y, x, 32'd0, 4'($urandom)});
  endtask

  // Pauses the sender until every expected result beat has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
      default: return $urandom;
    endcase
  endfunction

  // A plausible camera: focal length, centre and depth row, with random jitter.
  task automatic load_camera();
    logic [31:0] m[ppp_pkg::NCOEF];
    m[0] = 32'($urandom_range(2000, 100)) << 16;
    m[1] = $urandom_range(1) ? 32'($signed($urandom_range(1 << 16)) - (1 << 15)) : 32'd0;
    m[2] = 32'($urandom_range(700)) << 12;
    m[3] = 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    m[4] = 32'($signed($urandom_range(1 << 16)) - (1 << 15));
    m[5] = 32'($urandom_range(2000, 100)) << 16;
    m[6] = 32'($urandom_range(500)) << 12;
    m[7] = 32'($signed($urandom_range(1 << 20)) - (1 << 19));
    m[8] = 32'($signed($urandom_range(1 << 12)) - (1 << 11));
    m[9] = 32'($signed($urandom_range(1 << 12)) - (1 << 11));
    m[10] = 32'h0001_0000;
    m[11] = 32'($urandom_range(1 << 18));
    for (int i = 0; i < ppp_pkg::NCOEF; i++) load_coef(4'(i), m[i]);
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0: load_camera();
        1: load_coef(4'($urandom), rand_word());
        2: project_point(rand_word(), rand_word(), rand_word(), rand_word());
        3: project_point(32'($urandom), 32'($urandom), 32'd0, 32'd0);
        default:
          project_point(32'($signed($urandom_range(40 << 16)) - (20 << 16)),
                        32'($signed($urandom_range(40 << 16)) - (20 << 16)),
                        32'($signed($urandom_range(52 << 16)) - (2 << 16)),
                        $urandom_range(3) ? 32'h0001_0000 : rand_word());
      endcase
    end
  endtask

  initial begin
    board = new();
    board.clear();
    send_idle_pct = 12;
    recv_idle_pct = 45;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = ppp_pkg::OP_LOAD;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero matrix gives zero depth, ignored indexes, extremes of the sums.
    project_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
    load_coef(4'd12, 32'h7FFF_FFFF);
    load_coef(4'd15, 32'h8000_0000);
    project_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    load_coef(4'd0, 32'h8000_0000);
    load_coef(4'd5, 32'h7FFF_FFFF);
    load_coef(4'd10, 32'h0000_0001);
    project_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
    project_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0);
    project_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0);
    load_coef(4'd0, 32'h0001_0000);
    load_coef(4'd5, 32'h0001_0000);
    load_coef(4'd10, 32'hFFFF_0000);
    project_point(32'h0005_0000, 32'hFFFD_0000, 32'h0002_0000, 32'h0);
    project_point(32'h0005_0000, 32'h7FFF_0000, 32'h0001_0000, 32'h0);
    project_point(32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0);
    project_point(32'h0007_0000, 32'h0007_0000, 32'h0000_0000, 32'h0);
    for (int i = 0; i < ppp_pkg::NCOEF; i++) load_coef(4'(i), 32'hFFFF_FFFF);
    project_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();

    random_phase(390);
    drain();
    send_idle_pct = 45;
    recv_idle_pct = 12;
    random_phase(390);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(390);
    drain();
    repeat (80) @(posedge clk);

    $display("Covered %0d loads and %0d points, %0d at zero depth and %0d saturated,",
             board.loads, board.points, board.zeros, board.sats);
    $display("under three sender and receiver stall patterns.");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: files.f
design/ppp_pkg.sv
design/ppp_div_cell.sv
design/pinhole_point_projector_unit.sv
verif/pinhole_point_projector_unit_tb.sv
